// ----- rtl/tce_pkg.sv -----
// Package for the text console engine: request/response item types,
// request codes and character codes. No dependencies.
package tce_pkg;

    // Request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Control and fill characters
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LAST  = 8'h7F;

    localparam logic [7:0] RESET_COLOR = 8'h07;
    localparam logic [15:0] RESET_BLANK = {RESET_COLOR, CH_SPACE};

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  ch;
        logic [10:0] cell_index;
    } tce_req_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_index;
        logic [15:0] cell_value;
        logic        scrolled;
    } tce_rsp_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_FILL,
        ST_COPY,
        ST_BLANK,
        ST_EMIT
    } tce_state_t;

endpackage

// ----- rtl/text_console_engine_unit.sv -----
// Text console engine top level: screen memory, cursor and request sequencer.
// Depends on tce_pkg for item types, request codes and character codes.
//
// Usage
//   Request channel (req_valid/req_stall/req): one item per request, taken at
//   a rising edge with req_valid high and req_stall low. Put character, read
//   cell or clear screen. Response channel (rsp_valid/rsp_stall/rsp): one
//   item per request, in order, reporting the cursor after the request.
//   Config channel (cfg_valid/cfg_ready/cfg_data): writes the text color used
//   for new and blanked cells; always ready.
// Sequencing (one request in flight at a time)
//   put character: executed, then the response is emitted.
//   read cell: executed, the cell is read, then the response is emitted.
//   clear screen: blanks every cell; scroll copies rows up and blanks the last.
//   The long cases are set by the screen memory's single write port: one cell
//   is copied or blanked per cycle.
// Reset
//   The cursor homes, the color returns to 7 and a clearing pass writes blank
//   cells over the whole screen, during which no request is taken (config
//   writes are still taken).
// Stall
//   A finished response waits in the output register; the next request is
//   still taken and its response holds in the sequencer until the register
//   frees up.
module text_console_engine_unit
    import tce_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  tce_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output tce_rsp_t rsp,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [7:0] cfg_data
);

    localparam int NCELLS = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    // Column scratch must hold the tab overshoot, row scratch the row past the end
    localparam int CN_W   = $clog2(COLUMNS + 8);
    localparam int RN_W   = $clog2(ROWS + 1);

    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(NCELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(NCELLS - COLUMNS);

    // Screen memory, one write and one registered read per cycle
    logic [15:0] screen_mem [NCELLS];
    logic [15:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_wdata;

    tce_state_t state_reg, state_next;

    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [7:0]        text_color_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic              copy_v_reg;
    logic [ADDR_W-1:0] copy_addr_reg;
    logic [15:0]       fill_val_reg;
    tce_req_t          req_reg;
    logic              rd_ok_reg;
    logic [15:0]       value_reg;
    logic              scrolled_reg;
    logic              rsp_valid_reg;
    tce_rsp_t          rsp_reg;

    logic [ADDR_W-1:0] cur_addr;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  put_row;
    logic              put_scroll;
    logic              put_print;
    logic              rsp_free;
    logic              req_take;

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_take  = req_valid && !req_stall;
    assign cur_addr  = ADDR_W'(cur_row_reg) * ROW_STRIDE + ADDR_W'(cur_col_reg);

    // Put character: cursor motion, wrap and scroll decision
    always_comb
    begin
        logic [CN_W-1:0] col_a;
        logic [RN_W-1:0] row_a;
        col_a      = CN_W'(cur_col_reg);
        row_a      = RN_W'(cur_row_reg);
        put_scroll = 1'b0;
        put_print  = (req_reg.ch >= CH_SPACE) && (req_reg.ch <= CH_LAST);
        priority if (req_reg.ch == CH_BS)
        begin
            if (col_a != '0)
                col_a = col_a - CN_W'(1);
        end
        else if (req_reg.ch == CH_TAB)
        begin
            col_a = (col_a + CN_W'(8)) & ~CN_W'(7);
        end
        else if (req_reg.ch == CH_CR)
        begin
            col_a = '0;
        end
        else if (req_reg.ch == CH_LF)
        begin
            col_a = '0;
            row_a = row_a + RN_W'(1);
        end
        else if (put_print)
        begin
            col_a = col_a + CN_W'(1);
        end
        if (col_a >= CN_W'(COLUMNS))
        begin
            col_a = '0;
            row_a = row_a + RN_W'(1);
        end
        if (row_a >= RN_W'(ROWS))
        begin
            row_a      = RN_W'(ROWS - 1);
            put_scroll = 1'b1;
        end
        put_col = COL_W'(col_a);
        put_row = ROW_W'(row_a);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
                if (cnt_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (req_valid)
                    state_next = ST_EXEC;
            ST_EXEC:
                unique case (req_reg.req_type)
                    REQ_PUT:   state_next = put_scroll ? ST_COPY : ST_EMIT;
                    REQ_READ:  state_next = ST_READ;
                    REQ_CLEAR: state_next = ST_FILL;
                    default:   state_next = ST_EMIT;
                endcase
            ST_READ:
                state_next = ST_EMIT;
            ST_FILL:
                if (cnt_reg == LAST_ADDR)
                    state_next = ST_EMIT;
            ST_COPY:
                if (cnt_reg == LAST_ADDR)
                    state_next = ST_BLANK;
            ST_BLANK:
                if (!copy_v_reg && cnt_reg == LAST_ADDR)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (rsp_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs: request stall and memory port control
    always_comb
    begin
        req_stall = (state_reg != ST_IDLE);
        mem_raddr = (state_reg == ST_COPY) ? cnt_reg : ADDR_W'(req_reg.cell_index);
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = fill_val_reg;
        // Finish the copy pipeline before any blank write
        priority if (copy_v_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = copy_addr_reg;
            mem_wdata = rd_data_reg;
        end
        else if (state_reg == ST_INIT || state_reg == ST_FILL || state_reg == ST_BLANK)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == ST_EXEC && req_reg.req_type == REQ_PUT && put_print)
        begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr;
            mem_wdata = {text_color_reg, req_reg.ch};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= screen_mem[mem_raddr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            text_color_reg <= RESET_COLOR;
            cnt_reg        <= '0;
            copy_v_reg     <= 1'b0;
            fill_val_reg   <= RESET_BLANK;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            copy_v_reg <= (state_reg == ST_COPY);
            if (cfg_valid && cfg_ready)
                text_color_reg <= cfg_data;
            unique case (state_reg)
                ST_INIT, ST_FILL:
                    cnt_reg <= cnt_reg + ADDR_W'(1);
                ST_EXEC:
                begin
                    fill_val_reg <= {text_color_reg, CH_SPACE};
                    if (req_reg.req_type == REQ_PUT)
                    begin
                        cur_col_reg <= put_col;
                        cur_row_reg <= put_row;
                        cnt_reg     <= ROW_STRIDE;
                    end
                    else if (req_reg.req_type == REQ_CLEAR)
                    begin
                        cur_col_reg <= '0;
                        cur_row_reg <= '0;
                        cnt_reg     <= '0;
                    end
                end
                ST_COPY:
                    cnt_reg <= (cnt_reg == LAST_ADDR) ? BOTTOM_BASE : cnt_reg + ADDR_W'(1);
                ST_BLANK:
                    if (!copy_v_reg)
                        cnt_reg <= cnt_reg + ADDR_W'(1);
                default:
                    cnt_reg <= cnt_reg;
            endcase
            if (state_reg == ST_EMIT && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg   <= req;
            rd_ok_reg <= (32'(req.cell_index) < NCELLS);
        end
        // Destination of the cell read this cycle: one line up
        if (state_reg == ST_COPY)
            copy_addr_reg <= cnt_reg - ROW_STRIDE;
        if (state_reg == ST_EXEC)
        begin
            value_reg    <= '0;
            scrolled_reg <= (req_reg.req_type == REQ_PUT) && put_scroll;
        end
        if (state_reg == ST_READ)
            value_reg <= rd_ok_reg ? rd_data_reg : 16'h0000;
        if (state_reg == ST_EMIT && rsp_free)
        begin
            rsp_reg.cursor_col   <= 7'(cur_col_reg);
            rsp_reg.cursor_row   <= 5'(cur_row_reg);
            rsp_reg.cursor_index <= 11'(cur_addr);
            rsp_reg.cell_value   <= value_reg;
            rsp_reg.scrolled     <= scrolled_reg;
        end
    end

endmodule

// ----- verif/text_console_engine_unit_tb.sv -----
// Self-checking testbench for text_console_engine_unit: a screen/cursor
// predictor checks every response item. Depends on tce_pkg and the RTL top.
module text_console_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tce_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int NCELLS  = COLUMNS * ROWS;
    localparam int CELL_INDEX_TOP = 2047;     // largest value the 11-bit field carries

    // Request code 3 has no meaning: the block must leave everything alone.
    localparam logic [1:0] REQ_NOP = 2'd3;

    localparam int CLK_PERIOD       = 20;
    localparam int ITEMS_PER_PHASE  = 150;
    localparam int NUM_PHASES       = 6;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = 20;

    // Slowest correct run: ~925 items, each a scroll or clear plus the longest
    // gap and stall, is about 38 ms. Allow roughly ten times that.
    localparam longint TIMEOUT_NS = 64'd400_000_000;

    // ------------------------------------------------------------------
    // Screen and cursor predictor; holds the responses still owed by the block.
    // ------------------------------------------------------------------
    class console_scoreboard;
        logic [15:0] cells [NCELLS];
        int          col;
        int          row;
        logic [7:0]  color;
        tce_rsp_t    due_reports [$];
        int          errors;

        function new();
            color  = RESET_COLOR;
            col    = 0;
            row    = 0;
            errors = 0;
            blank_screen();
        endfunction

        function void set_color(logic [7:0] c);
            color = c;
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        function void blank_screen();
            foreach (cells[i])
                cells[i] = {color, CH_SPACE};
        endfunction

        // Apply one put character; return 1 when the screen scrolled.
        function bit put_char(logic [7:0] c);
            bit did_scroll;
            did_scroll = 1'b0;
            if (c == CH_BS)
            begin
                if (col != 0)
                    col--;
            end
            else if (c == CH_TAB)
            begin
                col = (col + 8) & ~7;
            end
            else if (c == CH_CR)
            begin
                col = 0;
            end
            else if (c == CH_LF)
            begin
                col = 0;
                row++;
            end
            else if (c >= CH_SPACE && c <= CH_LAST)
            begin
                cells[row * COLUMNS + col] = {color, c};
                col++;
            end
            if (col >= COLUMNS)
            begin
                col = 0;
                row++;
            end
            if (row >= ROWS)
            begin
                for (int i = 0; i < NCELLS - COLUMNS; i++)
                    cells[i] = cells[i + COLUMNS];
                for (int i = NCELLS - COLUMNS; i < NCELLS; i++)
                    cells[i] = {color, CH_SPACE};
                row        = ROWS - 1;
                did_scroll = 1'b1;
            end
            return did_scroll;
        endfunction

        function void note_request(tce_req_t r);
            tce_rsp_t want;
            want = '0;
            case (r.req_type)
                REQ_PUT:   want.scrolled = put_char(r.ch);
                REQ_READ:  if (r.cell_index < NCELLS) want.cell_value = cells[r.cell_index];
                REQ_CLEAR:
                begin
                    blank_screen();
                    col = 0;
                    row = 0;
                end
                default: ;
            endcase
            want.cursor_col   = col[6:0];
            want.cursor_row   = row[4:0];
            want.cursor_index = 11'(row * COLUMNS + col);
            due_reports.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
            if (want !== seen)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_response(tce_rsp_t got);
            tce_rsp_t want;
            if (due_reports.size() == 0)
            begin
                $display("%0t: response with none outstanding, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            compare_field("cursor_col",   want.cursor_col,   got.cursor_col);
            compare_field("cursor_row",   want.cursor_row,   got.cursor_row);
            compare_field("cursor_index", want.cursor_index, got.cursor_index);
            compare_field("cell_value",   want.cell_value,   got.cell_value);
            compare_field("scrolled",     want.scrolled,     got.scrolled);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports; every input known from time zero.
    // ------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    tce_req_t   req       = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    tce_rsp_t   rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = 8'h00;

    // Shared knobs between the stimulus and the response sink.
    bit idle_en       = 1'b1;   // random idle bursts on both sides
    bit long_hold_req = 1'b0;   // one long receiver hold-off, then clear
    int items_sent    = 0;

    console_scoreboard sb = new();

    always #(CLK_PERIOD / 2) clk = ~clk;

    text_console_engine_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Sample both channels at the rising edge; inputs only move at the
    // falling edge, so nothing here races with the block's own updates.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            if (req_valid && !req_stall)
                sb.note_request(req);
        end
    end

    // Response sink: random stall bursts, plus one long hold-off on request so
    // the block backs up and stalls its input.
    // Exactly one assignment to rsp_stall per falling edge.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES - 1;
                rsp_stall    <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                hold_left  = $urandom_range(0, 7);
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    function automatic tce_req_t make_req(logic [1:0] kind, logic [7:0] c, logic [10:0] idx);
        tce_req_t r;
        r.req_type   = kind;
        r.ch         = c;
        r.cell_index = idx;
        return r;
    endfunction

    // Offer one item and hold it until taken. Call at a falling edge;
    // returns at the falling edge after acceptance with valid still high,
    // so back-to-back items drop valid in between only for a random idle gap.
    task automatic send_req(tce_req_t item);
        int gap;
        gap = (idle_en && $urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed response has come back.
    task automatic drain_responses();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Write the text color; only called while the block is idle.
    task automatic write_color(logic [7:0] c);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_color(c);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Pick a cell to read: near the cursor, in the bottom rows, anywhere on
    // the screen, or anywhere the field reaches (past the end reads as 0).
    function automatic logic [10:0] pick_cell();
        int here;
        here = sb.row * COLUMNS + sb.col;
        case ($urandom_range(0, 3))
            0:       return 11'((here >= 8) ? here - $urandom_range(1, 8)
                                            : $urandom_range(0, 7));
            1:       return 11'((ROWS - 2) * COLUMNS + $urandom_range(0, 2 * COLUMNS - 1));
            2:       return 11'($urandom_range(0, NCELLS - 1));
            default: return 11'($urandom_range(0, CELL_INDEX_TOP));
        endcase
    endfunction

    // One well-formed burst of console traffic with random content; most
    // are short text lines so the cursor reaches the bottom and scrolls.
    task automatic send_sequence();
        int         kind;
        int         len;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            // text line: mostly short, now and then long enough to wrap
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 100)
                                                : $urandom_range(0, 12);
            repeat (len)
            begin
                case ($urandom_range(0, 39))
                    0:       c = CH_BS;
                    1:       c = CH_TAB;
                    2:       c = 8'($urandom_range(0, 255));
                    default: c = 8'($urandom_range(CH_SPACE, CH_LAST));
                endcase
                send_req(make_req(REQ_PUT, c, 11'($urandom_range(0, CELL_INDEX_TOP))));
            end
            len = $urandom_range(0, 9);
            if (len >= 7 && len < 9)
                send_req(make_req(REQ_PUT, CH_CR, 11'($urandom_range(0, CELL_INDEX_TOP))));
            if (len < 9)
                send_req(make_req(REQ_PUT, CH_LF, 11'($urandom_range(0, CELL_INDEX_TOP))));
        end
        else if (kind < 80)
        begin
            // read back cells
            repeat ($urandom_range(1, 6))
                send_req(make_req(REQ_READ, 8'($urandom_range(0, 255)), pick_cell()));
        end
        else if (kind < 88)
        begin
            // tab run with a few backspaces; crosses the last column
            repeat ($urandom_range(1, 12))
            begin
                c = ($urandom_range(0, 4) == 0) ? CH_BS : CH_TAB;
                send_req(make_req(REQ_PUT, c, 11'($urandom_range(0, CELL_INDEX_TOP))));
            end
        end
        else if (kind < 97)
        begin
            // noise: any byte, any index, including the unused request code
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 2))
                    0:       c = 8'(REQ_PUT);
                    1:       c = 8'(REQ_READ);
                    default: c = 8'(REQ_NOP);
                endcase
                send_req(make_req(c[1:0], 8'($urandom_range(0, 255)),
                                  11'($urandom_range(0, CELL_INDEX_TOP))));
            end
        end
        else if (kind < 98)
        begin
            send_req(make_req(REQ_CLEAR, 8'($urandom_range(0, 255)),
                              11'($urandom_range(0, CELL_INDEX_TOP))));
        end
        else
        begin
            send_req(make_req(REQ_NOP, 8'($urandom_range(0, 255)),
                              11'($urandom_range(0, CELL_INDEX_TOP))));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed items, then random phases, each with
    // its own text color written while the block is idle.
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] phase_color;
        int         phase_end;

        // hold reset, release at a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset screen and color, range ends of the read index,
        // backspace at column 0, printable range ends, ignored bytes,
        // tab, carriage return, line feed, unknown request, clear.
        send_req(make_req(REQ_READ, 8'h00, 11'd0));
        send_req(make_req(REQ_READ, 8'hFF, 11'(NCELLS - 1)));
        send_req(make_req(REQ_READ, 8'h00, 11'(NCELLS)));
        send_req(make_req(REQ_READ, 8'h00, 11'(CELL_INDEX_TOP)));
        send_req(make_req(REQ_PUT,  CH_BS,    11'd0));
        send_req(make_req(REQ_PUT,  CH_SPACE, 11'd0));
        send_req(make_req(REQ_PUT,  CH_LAST,  11'(CELL_INDEX_TOP)));
        send_req(make_req(REQ_PUT,  8'h00,    11'd0));
        send_req(make_req(REQ_PUT,  8'h1F,    11'd0));
        send_req(make_req(REQ_PUT,  8'h80,    11'd0));
        send_req(make_req(REQ_PUT,  8'hFF,    11'd0));
        send_req(make_req(REQ_PUT,  CH_BS,    11'd0));
        send_req(make_req(REQ_PUT,  CH_TAB,   11'd0));
        send_req(make_req(REQ_PUT,  CH_TAB,   11'd0));
        send_req(make_req(REQ_READ, 8'h00,    11'd0));
        send_req(make_req(REQ_READ, 8'h00,    11'd1));
        send_req(make_req(REQ_PUT,  CH_CR,    11'd0));
        send_req(make_req(REQ_PUT,  CH_LF,    11'd0));
        send_req(make_req(REQ_NOP,  8'hFF,    11'(CELL_INDEX_TOP)));
        send_req(make_req(REQ_CLEAR, 8'h00,   11'd0));
        send_req(make_req(REQ_READ, 8'h00,    11'd1));
        drain_responses();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // extremes first, then random colors
            if (p == 0)
                phase_color = 8'h00;
            else if (p == 1)
                phase_color = 8'hFF;
            else
                phase_color = 8'($urandom_range(0, 255));
            write_color(phase_color);

            // last phase runs flat out on both sides
            idle_en = (p != NUM_PHASES - 1);

            // first phase: hold off the sink while items keep coming
            if (p == 0)
                long_hold_req = 1'b1;

            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end)
                send_sequence();
            drain_responses();
        end

        // let any stray response show up before the verdict
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
